// ===== design/atr_lt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atr_lt_pkg;

    // Beat action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Reported status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_NOANS   = 3'd4;

    // One result beat
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] atr_length;
        logic       is_t1;
        logic [7:0] first_ta;
    } atr_lt_result_t;

endpackage

`default_nettype wire

// ===== design/atr_lt_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atr_lt_state #(
    parameter int MAX_ATR_BYTES = 40
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire logic [1:0]                 action,
    input  wire logic [7:0]                 byte_value,
    output atr_lt_pkg::atr_lt_result_t      result
);
    import atr_lt_pkg::*;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_TAIL  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    localparam logic [6:0] MAX_TOTAL = 7'(MAX_ATR_BYTES);

    phase_t     phase_reg, phase_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [3:0] pend_reg, pend_next;
    logic [1:0] grp_reg, grp_next;
    logic [3:0] hist_reg, hist_next;
    logic [5:0] exp_reg, exp_next;
    logic       t1_reg, t1_next;
    logic [7:0] ta1_reg, ta1_next;
    logic [2:0] status_reg, status_next;
    logic       hdr_done;
    logic [6:0] sum;

    // Per-beat update of the ATR walker
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        grp_next    = grp_reg;
        hist_next   = hist_reg;
        exp_next    = exp_reg;
        t1_next     = t1_reg;
        ta1_next    = ta1_reg;
        status_next = status_reg;
        hdr_done    = 1'b0;
        sum         = '0;

        unique case (action)
            ACT_BYTE:
            begin
                if (phase_reg != PH_DONE)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    unique case (phase_reg)
                        PH_TS:
                        begin
                            phase_next = PH_T0;
                        end
                        PH_T0:
                        begin
                            hist_next = byte_value[3:0];
                            pend_next = byte_value[7:4];
                            grp_next  = 2'd1;
                            if (byte_value[7:4] == 4'd0)
                                hdr_done = 1'b1;
                            else
                                phase_next = PH_IFACE;
                        end
                        PH_IFACE:
                        begin
                            // TA, TB, TC, then TD of the current group
                            if (pend_reg[0])
                            begin
                                if (grp_reg == 2'd1)
                                    ta1_next = byte_value;
                                pend_next = pend_reg & 4'b1110;
                            end
                            else if (pend_reg[1])
                            begin
                                pend_next = pend_reg & 4'b1101;
                            end
                            else if (pend_reg[2])
                            begin
                                pend_next = pend_reg & 4'b1011;
                            end
                            else
                            begin
                                // TD1 low nibble 1 or TD2 present means T=1
                                if (grp_reg == 2'd1 &&
                                    (byte_value[3:0] == 4'd1 || byte_value[7]))
                                    t1_next = 1'b1;
                                pend_next = byte_value[7:4];
                                if (grp_reg != 2'd3)
                                    grp_next = grp_reg + 2'd1;
                            end
                            hdr_done = (pend_next == 4'd0);
                        end
                        default:
                        begin
                        end
                    endcase

                    // Interface bytes finished: predict total length
                    if (hdr_done)
                    begin
                        sum = {1'b0, cnt_next} + {3'd0, hist_next} + {6'd0, t1_next};
                        exp_next   = (sum > MAX_TOTAL) ? 6'd0 : sum[5:0];
                        phase_next = PH_TAIL;
                    end

                    // Completion wins over capacity
                    if (phase_next == PH_TAIL && cnt_next == exp_next)
                    begin
                        phase_next  = PH_DONE;
                        status_next = ST_DONE;
                    end
                    else if ({1'b0, cnt_next} >= MAX_TOTAL)
                    begin
                        phase_next  = PH_DONE;
                        status_next = ST_FULL;
                    end
                end
            end
            ACT_TIMEOUT:
            begin
                if (phase_reg != PH_DONE)
                begin
                    status_next = (cnt_reg == 6'd0) ? ST_NOANS : ST_TIMEOUT;
                    phase_next  = PH_DONE;
                end
            end
            ACT_RESTART:
            begin
                phase_next  = PH_TS;
                cnt_next    = '0;
                pend_next   = '0;
                grp_next    = '0;
                hist_next   = '0;
                exp_next    = '0;
                t1_next     = 1'b0;
                ta1_next    = '0;
                status_next = ST_BUSY;
            end
            default:
            begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TS;
            cnt_reg    <= '0;
            pend_reg   <= '0;
            grp_reg    <= '0;
            hist_reg   <= '0;
            exp_reg    <= '0;
            t1_reg     <= 1'b0;
            ta1_reg    <= '0;
            status_reg <= ST_BUSY;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            grp_reg    <= grp_next;
            hist_reg   <= hist_next;
            exp_reg    <= exp_next;
            t1_reg     <= t1_next;
            ta1_reg    <= ta1_next;
            status_reg <= status_next;
        end
    end

    // Result reflects the state after this beat
    assign result.status     = status_next;
    assign result.atr_length = cnt_next;
    assign result.is_t1      = t1_next;
    assign result.first_ta   = ta1_next;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && action == ACT_RESTART |=> cnt_reg == 6'd0 && status_reg == ST_BUSY)
        else $error("restart did not clear the walker");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cnt_reg} <= MAX_TOTAL)
        else $error("byte count beyond capacity");

    a_status_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != ST_BUSY) == (phase_reg == PH_DONE))
        else $error("final status and finished phase disagree");

endmodule

`default_nettype wire

// ===== design/atr_length_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tracks a smart card Answer-To-Reset byte by byte and returns one result beat
// per input beat: status, bytes counted so far, the T=1 flag and TA1. A beat
// is a received byte, a receive timeout or a restart. One beat is taken every
// cycle while in_stall is low. A beat passes the input register, then the
// state update, then the result register before its result appears on the
// outputs. With the result register held by out_stall, one more beat waits
// in the input register before in_stall rises.
module atr_length_tracker #(
    parameter int MAX_ATR_BYTES = 40
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] byte_value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [5:0]      atr_length,
    output logic            is_t1,
    output logic [7:0]      first_ta
);
    import atr_lt_pkg::*;

    logic           s1_valid_reg;
    logic [1:0]     s1_action_reg;
    logic [7:0]     s1_byte_reg;
    logic           out_valid_reg;
    atr_lt_result_t out_reg;
    atr_lt_result_t result;
    logic           advance;
    logic           in_take;

    // Input beat moves on when the result register is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    atr_lt_state #(
        .MAX_ATR_BYTES (MAX_ATR_BYTES)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .action     (s1_action_reg),
        .byte_value (s1_byte_reg),
        .result     (result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= byte_value;
        end
        if (advance)
            out_reg <= result;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign atr_length = out_reg.atr_length;
    assign is_t1      = out_reg.is_t1;
    assign first_ta   = out_reg.first_ta;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("moved beat produced no result");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire
